[src/obla_pkg.sv]
// ----------------------------------------------------------------------------
// obla_pkg
// Shared constants, codes and types of the order book level aggregator.
// ----------------------------------------------------------------------------
package obla_pkg;

    // Sizing
    localparam int ORDER_SLOTS  = 65536;
    localparam int PRICE_LEVELS = 1024;
    localparam int TOTAL_BITS   = 48;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int ID_W     = 16;
    localparam int PRICE_W  = 32;
    localparam int QTY_W    = 32;
    localparam int STAT_W   = 2;
    localparam int OUT_TOT_W = 48;

    // Derived widths
    localparam int ORD_AW    = $clog2(ORDER_SLOTS);
    localparam int LVL_IDX_W = $clog2(PRICE_LEVELS);
    localparam int LVL_DEPTH = 2 * PRICE_LEVELS;
    localparam int LVL_AW    = LVL_IDX_W + 1;
    localparam int CLR_N     = (ORDER_SLOTS > LVL_DEPTH) ? ORDER_SLOTS : LVL_DEPTH;
    localparam int CLR_W     = $clog2(CLR_N);

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_NEW    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHANGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd3;

    // Order table entry
    typedef struct packed {
        logic                 live;
        logic                 side;
        logic [LVL_IDX_W-1:0] level;
        logic [QTY_W-1:0]     qty;
    } ord_rec_t;

    localparam int ORD_REC_W = $bits(ord_rec_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ORD,
        ST_LV1,
        ST_LV2
    } state_t;

    // Datapath status towards the sequencer
    typedef struct packed {
        logic              in_valid;
        logic [MODE_W-1:0] mode;
        logic              id_bad;
        logic              rec_live;
        logic              win_ok;
        logic              out_free;
    } stat_t;

    // Sequencer commands towards the datapath
    typedef struct packed {
        logic              clr;
        logic              in_ready;
        logic              ord_wr;
        logic              lvl_rd;
        logic              lvl_rd_new;
        logic              lvl_wr;
        logic              op_add;
        logic              emit;
        logic              emit_reject;
        logic              last;
        logic [STAT_W-1:0] status;
    } ctrl_t;

endpackage

[src/obla_if.sv]
// ----------------------------------------------------------------------------
// obla channel interfaces
// Valid/ready channels for order words, level words and base writes.
// ----------------------------------------------------------------------------
interface obla_order_if
    import obla_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [ID_W-1:0]           ord_id;
    logic                      side;
    logic signed [PRICE_W-1:0] price;
    logic [QTY_W-1:0]          quantity;

    modport source (output valid, mode, ord_id, side, price, quantity, input ready);
    modport sink   (input valid, mode, ord_id, side, price, quantity, output ready);
endinterface

interface obla_level_if
    import obla_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic                      level_side;
    logic signed [PRICE_W-1:0] level_price;
    logic [OUT_TOT_W-1:0]      level_total;
    logic                      last;

    modport source (output valid, status, level_side, level_price, level_total, last,
                    input ready);
    modport sink   (input valid, status, level_side, level_price, level_total, last,
                    output ready);
endinterface

interface obla_cfg_if
    import obla_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [PRICE_W-1:0] price_window_base;

    modport source (output valid, price_window_base, input ready);
    modport sink   (input valid, price_window_base, output ready);
endinterface

[src/order_book_level_aggregator.sv]
// ----------------------------------------------------------------------------
// order_book_level_aggregator
// Order table and per-side price level totals with status reporting.
// ----------------------------------------------------------------------------
// Usage
//   order_in  : order words (mode, ord_id, side, price, quantity).
//   level_out : level words (status, level_side, level_price, level_total,
//               last); a change gives two words (old level, then new level),
//               an unused mode none, others one; a reject has zero level data.
//   cfg       : price_window_base writes, always ready; write it only while
//               the block is idle.
// Sequence (per accepted order word):
//   one order-table lookup, then one read-modify-write per level on the
//   level RAM (buy and sell halves share a single read/write port pair).
//   A rejected word skips the level steps; an unused mode gives no word.
//   order_in is ready again only once the block is back in idle.
// Reset: a clearing pass sweeps the order table and both level tables,
//   with order_in held not ready; cfg writes are taken throughout.
// Stall: a held level word stalls the sequencer at its next emit step; one
//   output register parts the two sides.
// ----------------------------------------------------------------------------
module order_book_level_aggregator
    import obla_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    obla_order_if.sink   order_in,
    obla_level_if.source level_out,
    obla_cfg_if.sink     cfg
);

    ctrl_t            ctrl;
    stat_t            stat;
    logic [CLR_W-1:0] clr_cnt;

    // Configuration
    logic signed [PRICE_W-1:0] base_reg, base_next;

    // Accepted order word
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic               side_reg, side_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [QTY_W-1:0]   qty_reg, qty_next;

    // Level step state
    logic [LVL_AW-1:0]     lvl_addr_reg, lvl_addr_next;
    logic                  fwd_reg, fwd_next;
    logic [TOTAL_BITS-1:0] wr_total_reg, wr_total_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]         out_status_reg, out_status_next;
    logic                      out_side_reg, out_side_next;
    logic signed [PRICE_W-1:0] out_price_reg, out_price_next;
    logic [OUT_TOT_W-1:0]      out_total_reg, out_total_next;
    logic                      out_last_reg, out_last_next;

    // Memory ports
    logic                  ord_we, ord_re;
    logic [ORD_AW-1:0]     ord_waddr, ord_raddr;
    logic [ORD_REC_W-1:0]  ord_wdata, ord_rdata;
    logic                  lvl_we;
    logic [LVL_AW-1:0]     lvl_waddr, lvl_raddr;
    logic [TOTAL_BITS-1:0] lvl_wdata, lvl_rdata;

    ord_rec_t              rec;
    ord_rec_t              rec_new;
    logic signed [PRICE_W:0] win_off;
    logic                  win_ok;
    logic [LVL_IDX_W-1:0]  win_idx;
    logic                  accept;
    logic                  out_free;
    logic                  clr_ord_ok, clr_lvl_ok;
    logic [TOTAL_BITS-1:0] total_old, total_new;
    logic [QTY_W-1:0]      upd_qty;
    logic                  rd_side;

    assign accept   = ctrl.in_ready && order_in.valid;
    assign out_free = !out_valid_reg || level_out.ready;
    assign rec      = ord_rec_t'(ord_rdata);

    // Window check: 33-bit signed offset of price from base
    assign win_off = $signed({price_reg[PRICE_W-1], price_reg})
                   - $signed({base_reg[PRICE_W-1], base_reg});
    assign win_ok  = !win_off[PRICE_W] && (win_off[PRICE_W-1:0] < PRICE_W'(PRICE_LEVELS));
    assign win_idx = win_off[LVL_IDX_W-1:0];

    assign stat.in_valid = order_in.valid;
    assign stat.mode     = mode_reg;
    assign stat.id_bad   = (int'(id_reg) >= ORDER_SLOTS);
    assign stat.rec_live = rec.live;
    assign stat.win_ok   = win_ok;
    assign stat.out_free = out_free;

    obla_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .stat    (stat),
        .ctrl    (ctrl),
        .clr_cnt (clr_cnt)
    );

    // Clearing pass bounds
    assign clr_ord_ok = ({1'b0, clr_cnt} < (CLR_W + 1)'(ORDER_SLOTS));
    assign clr_lvl_ok = ({1'b0, clr_cnt} < (CLR_W + 1)'(LVL_DEPTH));

    // Order table entry after this word: cancel only drops the live flag
    always_comb
    begin
        rec_new = rec;
        if (mode_reg == MODE_CANCEL)
        begin
            rec_new.live = 1'b0;
        end
        else
        begin
            rec_new.live  = 1'b1;
            rec_new.side  = (mode_reg == MODE_NEW) ? side_reg : rec.side;
            rec_new.level = win_idx;
            rec_new.qty   = qty_reg;
        end
    end

    assign ord_re    = accept;
    assign ord_raddr = ORD_AW'(order_in.ord_id);
    assign ord_we    = ctrl.clr ? clr_ord_ok : ctrl.ord_wr;
    assign ord_waddr = ctrl.clr ? clr_cnt[ORD_AW-1:0] : ORD_AW'(id_reg);
    assign ord_wdata = ctrl.clr ? '0 : ORD_REC_W'(rec_new);

    obla_ram #(
        .WIDTH (ORD_REC_W),
        .DEPTH (ORDER_SLOTS)
    ) u_ord_ram (
        .clk     (clk),
        .wr_en   (ord_we),
        .wr_addr (ord_waddr),
        .wr_data (ord_wdata),
        .rd_en   (ord_re),
        .rd_addr (ord_raddr),
        .rd_data (ord_rdata)
    );

    // Level address: {side, index}; old level from the entry, new from price
    assign rd_side   = (mode_reg == MODE_NEW) ? side_reg : rec.side;
    assign lvl_raddr = ctrl.lvl_rd_new ? {rd_side, win_idx} : {rec.side, rec.level};

    // Same-level change: second read overlaps the first write-back
    assign total_old = fwd_reg ? wr_total_reg : lvl_rdata;
    assign upd_qty   = ctrl.op_add ? qty_reg : rec.qty;

    obla_level_upd u_level_upd (
        .op_add    (ctrl.op_add),
        .total_in  (total_old),
        .qty       (upd_qty),
        .total_out (total_new)
    );

    assign lvl_we    = ctrl.clr ? clr_lvl_ok : ctrl.lvl_wr;
    assign lvl_waddr = ctrl.clr ? clr_cnt[LVL_AW-1:0] : lvl_addr_reg;
    assign lvl_wdata = ctrl.clr ? '0 : total_new;

    obla_ram #(
        .WIDTH (TOTAL_BITS),
        .DEPTH (LVL_DEPTH)
    ) u_lvl_ram (
        .clk     (clk),
        .wr_en   (lvl_we),
        .wr_addr (lvl_waddr),
        .wr_data (lvl_wdata),
        .rd_en   (ctrl.lvl_rd),
        .rd_addr (lvl_raddr),
        .rd_data (lvl_rdata)
    );

    // Next values
    always_comb
    begin
        base_next = cfg.valid ? cfg.price_window_base : base_reg;

        mode_next  = accept ? order_in.mode : mode_reg;
        id_next    = accept ? order_in.ord_id : id_reg;
        side_next  = accept ? order_in.side : side_reg;
        price_next = accept ? order_in.price : price_reg;
        qty_next   = accept ? order_in.quantity : qty_reg;

        lvl_addr_next = ctrl.lvl_rd ? lvl_raddr : lvl_addr_reg;
        fwd_next      = ctrl.lvl_rd ? (ctrl.lvl_wr && (lvl_addr_reg == lvl_raddr)) : fwd_reg;
        wr_total_next = ctrl.lvl_wr ? total_new : wr_total_reg;

        out_valid_next  = ctrl.emit ? 1'b1 : (level_out.ready ? 1'b0 : out_valid_reg);
        out_status_next = out_status_reg;
        out_side_next   = out_side_reg;
        out_price_next  = out_price_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        if (ctrl.emit)
        begin
            out_status_next = ctrl.status;
            out_last_next   = ctrl.last;
            if (ctrl.emit_reject)
            begin
                out_side_next  = 1'b0;
                out_price_next = '0;
                out_total_next = '0;
            end
            else
            begin
                // price uses the current base
                out_side_next  = lvl_addr_reg[LVL_AW-1];
                out_price_next = base_reg + PRICE_W'(lvl_addr_reg[LVL_IDX_W-1:0]);
                out_total_next = OUT_TOT_W'(total_new);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            fwd_reg       <= fwd_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        side_reg       <= side_next;
        price_reg      <= price_next;
        qty_reg        <= qty_next;
        lvl_addr_reg   <= lvl_addr_next;
        wr_total_reg   <= wr_total_next;
        out_status_reg <= out_status_next;
        out_side_reg   <= out_side_next;
        out_price_reg  <= out_price_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
    end

    assign order_in.ready        = ctrl.in_ready;
    assign cfg.ready             = 1'b1;
    assign level_out.valid       = out_valid_reg;
    assign level_out.status      = out_status_reg;
    assign level_out.level_side  = out_side_reg;
    assign level_out.level_price = out_price_reg;
    assign level_out.level_total = out_total_reg;
    assign level_out.last        = out_last_reg;

endmodule

[src/obla_ram.sv]
// ----------------------------------------------------------------------------
// obla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module obla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/obla_level_upd.sv]
// ----------------------------------------------------------------------------
// obla_level_upd
// Saturating add / floor-at-zero subtract of a quantity on a level total.
// ----------------------------------------------------------------------------
module obla_level_upd
    import obla_pkg::*;
(
    input  logic                  op_add,
    input  logic [TOTAL_BITS-1:0] total_in,
    input  logic [QTY_W-1:0]      qty,
    output logic [TOTAL_BITS-1:0] total_out
);

    logic [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS-1:0] qty_ext;

    assign qty_ext = TOTAL_BITS'(qty);
    assign sum     = {1'b0, total_in} + {1'b0, qty_ext};

    always_comb
    begin
        if (op_add)
        begin
            // carry out means past the all-ones maximum
            total_out = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
        end
        else
        begin
            total_out = (qty_ext > total_in) ? '0 : (total_in - qty_ext);
        end
    end

endmodule

[src/obla_ctrl.sv]
// ----------------------------------------------------------------------------
// obla_ctrl
// Sequencer: clearing pass, order lookup, level read-modify-write steps.
// ----------------------------------------------------------------------------
module obla_ctrl
    import obla_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stat_t            stat,
    output ctrl_t            ctrl,
    output logic [CLR_W-1:0] clr_cnt
);

    state_t            state_reg, state_next;
    logic [CLR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              clr_last;
    logic [STAT_W-1:0] verdict;

    assign clr_last = (clr_cnt_reg == CLR_W'(CLR_N - 1));
    assign clr_cnt  = clr_cnt_reg;

    // Rejection verdict from the looked-up entry
    always_comb
    begin
        verdict = STAT_OK;
        if (stat.id_bad)
        begin
            verdict = STAT_UNKNOWN;
        end
        else
        begin
            case (stat.mode)
                MODE_NEW:
                begin
                    if (stat.rec_live)
                        verdict = STAT_DUP;
                    else if (!stat.win_ok)
                        verdict = STAT_OUTSIDE;
                end
                MODE_CHANGE:
                begin
                    if (!stat.rec_live)
                        verdict = STAT_UNKNOWN;
                    else if (!stat.win_ok)
                        verdict = STAT_OUTSIDE;
                end
                MODE_CANCEL:
                begin
                    if (!stat.rec_live)
                        verdict = STAT_UNKNOWN;
                end
                default:
                begin
                    verdict = STAT_OK;
                end
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (stat.in_valid)
                    state_next = ST_ORD;
            end
            ST_ORD:
            begin
                if (stat.mode == MODE_NONE)
                    state_next = ST_IDLE;
                else if (verdict != STAT_OK)
                begin
                    if (stat.out_free)
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_LV1;
            end
            ST_LV1:
            begin
                if (stat.out_free)
                    state_next = (stat.mode == MODE_CHANGE) ? ST_LV2 : ST_IDLE;
            end
            ST_LV2:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        ctrl = '0;
        ctrl.status = STAT_OK;
        case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clr = 1'b1;
            end
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            ST_ORD:
            begin
                if (stat.mode != MODE_NONE)
                begin
                    if (verdict != STAT_OK)
                    begin
                        ctrl.emit        = stat.out_free;
                        ctrl.emit_reject = 1'b1;
                        ctrl.last        = 1'b1;
                        ctrl.status      = verdict;
                    end
                    else
                    begin
                        ctrl.ord_wr     = 1'b1;
                        ctrl.lvl_rd     = 1'b1;
                        ctrl.lvl_rd_new = (stat.mode == MODE_NEW);
                    end
                end
            end
            ST_LV1:
            begin
                ctrl.op_add = (stat.mode == MODE_NEW);
                ctrl.last   = (stat.mode != MODE_CHANGE);
                if (stat.out_free)
                begin
                    ctrl.lvl_wr = 1'b1;
                    ctrl.emit   = 1'b1;
                    if (stat.mode == MODE_CHANGE)
                    begin
                        ctrl.lvl_rd     = 1'b1;
                        ctrl.lvl_rd_new = 1'b1;
                    end
                end
            end
            ST_LV2:
            begin
                ctrl.op_add = 1'b1;
                ctrl.last   = 1'b1;
                if (stat.out_free)
                begin
                    ctrl.lvl_wr = 1'b1;
                    ctrl.emit   = 1'b1;
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign clr_cnt_next = (state_reg == ST_CLEAR) ? (clr_cnt_reg + 1'b1) : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

endmodule
